// File: rtl/imudr_pkg.sv
package imudr_pkg;

  localparam int QUAT_W  = 16;
  localparam int SAMP_W  = 16;
  localparam int DT_W    = 20;
  localparam int CPG_W   = 16;
  localparam int VEL_W   = 48;
  localparam int POS_W   = 64;
  localparam int VSUM_W  = VEL_W + 1;
  localparam int OPA_W   = 36;
  localparam int OPB_W   = 22;
  localparam int PROD_W  = OPA_W + OPB_W;
  localparam int ACC_W   = 72;
  localparam int VLO_W   = 24;

  localparam logic [CPG_W-1:0] CPG_RESET = 16'd16384;

  localparam int NUM_STEPS = 44;
  localparam int STEP_W    = 6;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_STEPS - 1);
  // last issue drains through product, accumulator, post and commit
  localparam logic [STEP_W-1:0] CNT_DRAIN = STEP_W'(NUM_STEPS + 2);

  localparam logic [1:0] QI_W = 2'd0;
  localparam logic [1:0] QI_X = 2'd1;
  localparam logic [1:0] QI_Y = 2'd2;
  localparam logic [1:0] QI_Z = 2'd3;
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic [2:0] {AK_Q, AK_G, AK_R, AK_AS, AK_VH, AK_VL} a_kind_e;
  typedef enum logic [1:0] {BK_Q, BK_L, BK_CPG, BK_DT} b_kind_e;
  typedef enum logic [1:0] {SH_0, SH_1, SH_24} shift_e;
  typedef enum logic [2:0] {PK_NONE, PK_GRAV, PK_LIN, PK_R, PK_ACC, PK_VEL, PK_POS} post_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  typedef struct packed {
    a_kind_e    a_kind;
    logic [1:0] a_idx;
    b_kind_e    b_kind;
    logic [1:0] b_idx;
    logic       neg;
    logic       first;
    shift_e     shift;
    post_e      post;
    logic [1:0] post_idx;
  } step_t;

  typedef struct packed {
    logic              load_in;
    logic              issue;
    logic [STEP_W-1:0] step;
    logic              load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [SAMP_W-1:0] accel_x;
    logic signed [SAMP_W-1:0] accel_y;
    logic signed [SAMP_W-1:0] accel_z;
    logic        [DT_W-1:0]   dt_ticks;
  } in_item_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } out_item_t;

  function automatic step_t mk(a_kind_e ak, logic [1:0] ai, b_kind_e bk, logic [1:0] bi,
                               logic ng, logic fs, shift_e sh, post_e pk, logic [1:0] pi);
    step_t s;
    s.a_kind   = ak;
    s.a_idx    = ai;
    s.b_kind   = bk;
    s.b_idx    = bi;
    s.neg      = ng;
    s.first    = fs;
    s.shift    = sh;
    s.post     = pk;
    s.post_idx = pi;
    return s;
  endfunction

  // microprogram: one multiply-accumulate per step
  function automatic step_t step_at(logic [STEP_W-1:0] idx);
    step_t s;
    case (idx)
      // gravity direction, factor two of x and y folded into the shift
      6'd0:  s = mk(AK_Q, QI_X, BK_Q, QI_Z, 1'b0, 1'b1, SH_1, PK_NONE, AX_X);
      6'd1:  s = mk(AK_Q, QI_W, BK_Q, QI_Y, 1'b1, 1'b0, SH_1, PK_GRAV, AX_X);
      6'd2:  s = mk(AK_Q, QI_W, BK_Q, QI_X, 1'b0, 1'b1, SH_1, PK_NONE, AX_Y);
      6'd3:  s = mk(AK_Q, QI_Y, BK_Q, QI_Z, 1'b0, 1'b0, SH_1, PK_GRAV, AX_Y);
      6'd4:  s = mk(AK_Q, QI_W, BK_Q, QI_W, 1'b0, 1'b1, SH_0, PK_NONE, AX_Z);
      6'd5:  s = mk(AK_Q, QI_X, BK_Q, QI_X, 1'b1, 1'b0, SH_0, PK_NONE, AX_Z);
      6'd6:  s = mk(AK_Q, QI_Y, BK_Q, QI_Y, 1'b1, 1'b0, SH_0, PK_NONE, AX_Z);
      6'd7:  s = mk(AK_Q, QI_Z, BK_Q, QI_Z, 1'b0, 1'b0, SH_0, PK_GRAV, AX_Z);
      // gravity counts and linear acceleration
      6'd8:  s = mk(AK_G, AX_X, BK_CPG, AX_X, 1'b0, 1'b1, SH_0, PK_LIN, AX_X);
      6'd9:  s = mk(AK_G, AX_Y, BK_CPG, AX_X, 1'b0, 1'b1, SH_0, PK_LIN, AX_Y);
      6'd10: s = mk(AK_G, AX_Z, BK_CPG, AX_X, 1'b0, 1'b1, SH_0, PK_LIN, AX_Z);
      // r = q * (0, l)
      6'd11: s = mk(AK_Q, QI_X, BK_L, AX_X, 1'b1, 1'b1, SH_0, PK_NONE, QI_W);
      6'd12: s = mk(AK_Q, QI_Y, BK_L, AX_Y, 1'b1, 1'b0, SH_0, PK_NONE, QI_W);
      6'd13: s = mk(AK_Q, QI_Z, BK_L, AX_Z, 1'b1, 1'b0, SH_0, PK_R,    QI_W);
      6'd14: s = mk(AK_Q, QI_W, BK_L, AX_X, 1'b0, 1'b1, SH_0, PK_NONE, QI_X);
      6'd15: s = mk(AK_Q, QI_Y, BK_L, AX_Z, 1'b0, 1'b0, SH_0, PK_NONE, QI_X);
      6'd16: s = mk(AK_Q, QI_Z, BK_L, AX_Y, 1'b1, 1'b0, SH_0, PK_R,    QI_X);
      6'd17: s = mk(AK_Q, QI_W, BK_L, AX_Y, 1'b0, 1'b1, SH_0, PK_NONE, QI_Y);
      6'd18: s = mk(AK_Q, QI_X, BK_L, AX_Z, 1'b1, 1'b0, SH_0, PK_NONE, QI_Y);
      6'd19: s = mk(AK_Q, QI_Z, BK_L, AX_X, 1'b0, 1'b0, SH_0, PK_R,    QI_Y);
      6'd20: s = mk(AK_Q, QI_W, BK_L, AX_Z, 1'b0, 1'b1, SH_0, PK_NONE, QI_Z);
      6'd21: s = mk(AK_Q, QI_X, BK_L, AX_Y, 1'b0, 1'b0, SH_0, PK_NONE, QI_Z);
      6'd22: s = mk(AK_Q, QI_Y, BK_L, AX_X, 1'b1, 1'b0, SH_0, PK_R,    QI_Z);
      // s = r * conj(q)
      6'd23: s = mk(AK_R, QI_W, BK_Q, QI_X, 1'b1, 1'b1, SH_0, PK_NONE, AX_X);
      6'd24: s = mk(AK_R, QI_X, BK_Q, QI_W, 1'b0, 1'b0, SH_0, PK_NONE, AX_X);
      6'd25: s = mk(AK_R, QI_Y, BK_Q, QI_Z, 1'b1, 1'b0, SH_0, PK_NONE, AX_X);
      6'd26: s = mk(AK_R, QI_Z, BK_Q, QI_Y, 1'b0, 1'b0, SH_0, PK_ACC,  AX_X);
      6'd27: s = mk(AK_R, QI_W, BK_Q, QI_Y, 1'b1, 1'b1, SH_0, PK_NONE, AX_Y);
      6'd28: s = mk(AK_R, QI_X, BK_Q, QI_Z, 1'b0, 1'b0, SH_0, PK_NONE, AX_Y);
      6'd29: s = mk(AK_R, QI_Y, BK_Q, QI_W, 1'b0, 1'b0, SH_0, PK_NONE, AX_Y);
      6'd30: s = mk(AK_R, QI_Z, BK_Q, QI_X, 1'b1, 1'b0, SH_0, PK_ACC,  AX_Y);
      6'd31: s = mk(AK_R, QI_W, BK_Q, QI_Z, 1'b1, 1'b1, SH_0, PK_NONE, AX_Z);
      6'd32: s = mk(AK_R, QI_X, BK_Q, QI_Y, 1'b1, 1'b0, SH_0, PK_NONE, AX_Z);
      6'd33: s = mk(AK_R, QI_Y, BK_Q, QI_X, 1'b0, 1'b0, SH_0, PK_NONE, AX_Z);
      6'd34: s = mk(AK_R, QI_Z, BK_Q, QI_W, 1'b0, 1'b0, SH_0, PK_ACC,  AX_Z);
      // velocity increments
      6'd35: s = mk(AK_AS, AX_X, BK_DT, AX_X, 1'b0, 1'b1, SH_0, PK_VEL, AX_X);
      6'd36: s = mk(AK_AS, AX_Y, BK_DT, AX_X, 1'b0, 1'b1, SH_0, PK_VEL, AX_Y);
      6'd37: s = mk(AK_AS, AX_Z, BK_DT, AX_X, 1'b0, 1'b1, SH_0, PK_VEL, AX_Z);
      // position increments, velocity sum split into high and low parts
      6'd38: s = mk(AK_VH, AX_X, BK_DT, AX_X, 1'b0, 1'b1, SH_24, PK_NONE, AX_X);
      6'd39: s = mk(AK_VL, AX_X, BK_DT, AX_X, 1'b0, 1'b0, SH_0,  PK_POS,  AX_X);
      6'd40: s = mk(AK_VH, AX_Y, BK_DT, AX_X, 1'b0, 1'b1, SH_24, PK_NONE, AX_Y);
      6'd41: s = mk(AK_VL, AX_Y, BK_DT, AX_X, 1'b0, 1'b0, SH_0,  PK_POS,  AX_Y);
      6'd42: s = mk(AK_VH, AX_Z, BK_DT, AX_X, 1'b0, 1'b1, SH_24, PK_NONE, AX_Z);
      6'd43: s = mk(AK_VL, AX_Z, BK_DT, AX_X, 1'b0, 1'b0, SH_0,  PK_POS,  AX_Z);
      default: s = mk(AK_Q, QI_W, BK_Q, QI_W, 1'b0, 1'b1, SH_0, PK_NONE, AX_X);
    endcase
    return s;
  endfunction

endpackage

// File: rtl/imudr_in_if.sv
interface imudr_in_if;
  import imudr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [QUAT_W-1:0] quat_w;
  logic signed [QUAT_W-1:0] quat_x;
  logic signed [QUAT_W-1:0] quat_y;
  logic signed [QUAT_W-1:0] quat_z;
  logic signed [SAMP_W-1:0] accel_x;
  logic signed [SAMP_W-1:0] accel_y;
  logic signed [SAMP_W-1:0] accel_z;
  logic        [DT_W-1:0]   dt_ticks;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z,
                  dt_ticks, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z,
                dt_ticks, output ready);
endinterface

// File: rtl/imudr_out_if.sv
interface imudr_out_if;
  import imudr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] vel_z;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;

  modport source (output valid, vel_x, vel_y, vel_z, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, pos_x, pos_y, pos_z, output ready);
endinterface

// File: rtl/imudr_cfg_if.sv
interface imudr_cfg_if;
  import imudr_pkg::*;
  logic             valid;
  logic             ready;
  logic [CPG_W-1:0] accel_counts_per_g;

  modport source (output valid, accel_counts_per_g, input ready);
  modport sink (input valid, accel_counts_per_g, output ready);
endinterface

// File: rtl/imu_dead_reckoning_integrator.sv
// Items are processed one at a time by the 44-step multiply-accumulate program
//   on the single shared multiplier, then pipeline drain and result load.
//   Input is taken only while idle; the load waits for a free output register.
// The next item is accepted while a result still waits in the output register.
// Reset (rst_ni low, asynchronous) clears velocity, position, previous acceleration,
//   the sequencer, and sets accel_counts_per_g to 16384.
module imu_dead_reckoning_integrator (
  input logic        clk_i,
  input logic        rst_ni,
  imudr_in_if.sink   in_i,
  imudr_out_if.source out_o,
  imudr_cfg_if.sink  cfg_i
);
  import imudr_pkg::*;

  dp_cmd_t   cmd;
  in_item_t  in_item;
  out_item_t out_item;
  logic      out_valid;

  // configuration always taken; user must write only while idle, not enforced
  assign cfg_i.ready = 1'b1;

  // gather the input transaction payload
  assign in_item.quat_w   = in_i.quat_w;
  assign in_item.quat_x   = in_i.quat_x;
  assign in_item.quat_y   = in_i.quat_y;
  assign in_item.quat_z   = in_i.quat_z;
  assign in_item.accel_x  = in_i.accel_x;
  assign in_item.accel_y  = in_i.accel_y;
  assign in_item.accel_z  = in_i.accel_z;
  assign in_item.dt_ticks = in_i.dt_ticks;

  // sequencer: accept, step the program, drain, load the output register
  imudr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // shared multiplier, accumulator and integrator state
  imudr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.accel_counts_per_g),
    .out_item_o  (out_item)
  );

  assign out_o.valid = out_valid;
  assign out_o.vel_x = out_item.vel_x;
  assign out_o.vel_y = out_item.vel_y;
  assign out_o.vel_z = out_item.vel_z;
  assign out_o.pos_x = out_item.pos_x;
  assign out_o.pos_y = out_item.pos_y;
  assign out_o.pos_z = out_item.pos_z;

endmodule

// File: rtl/imudr_ctrl.sv
module imudr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output imudr_pkg::dp_cmd_t cmd_o
);
  import imudr_pkg::*;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cnt_d         = '0;
          state_d       = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.issue = (cnt_q <= STEP_LAST);
        cmd_o.step  = cnt_q;
        cnt_d       = cnt_q + STEP_W'(1);
        if (cnt_q == CNT_DRAIN) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/imudr_dp.sv
module imudr_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  imudr_pkg::dp_cmd_t   cmd_i,
  input  imudr_pkg::in_item_t  in_item_i,
  input  logic                 cfg_valid_i,
  input  logic [imudr_pkg::CPG_W-1:0] cfg_data_i,
  output imudr_pkg::out_item_t out_item_o
);
  import imudr_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF_Q28 = ACC_W'(1) << 27;
  localparam logic signed [ACC_W-1:0] S16_MAX  = (ACC_W'(1) << (SAMP_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] S16_MIN  = ~S16_MAX;
  localparam logic signed [ACC_W-1:0] S48_MAX  = (ACC_W'(1) << (VEL_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] S48_MIN  = ~S48_MAX;
  localparam logic signed [ACC_W-1:0] S64_MAX  = (ACC_W'(1) << (POS_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] S64_MIN  = ~S64_MAX;

  function automatic logic signed [ACC_W-1:0] clamp(logic signed [ACC_W-1:0] v,
                                                    logic signed [ACC_W-1:0] lo,
                                                    logic signed [ACC_W-1:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [ACC_W-1:0] rnd28(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + HALF_Q28;
    return t >>> 28;
  endfunction

  logic [CPG_W-1:0]          cpg_q;
  logic signed [QUAT_W-1:0]  q_q    [4];
  logic signed [SAMP_W-1:0]  raw_q  [3];
  logic [DT_W-1:0]           dt_q;
  logic signed [OPA_W-1:0]   grav_q [3];
  logic signed [SAMP_W-1:0]  lin_q  [3];
  logic signed [OPA_W-1:0]   r_q    [4];
  logic signed [SAMP_W-1:0]  anew_q [3];
  logic signed [SAMP_W-1:0]  aprev_q[3];
  logic signed [VEL_W-1:0]   vel_q  [3];
  logic signed [VEL_W-1:0]   vnew_q [3];
  logic signed [VSUM_W-1:0]  vsum_q [3];
  logic signed [POS_W-1:0]   pos_q  [3];
  out_item_t                 out_q;

  step_t                     st;
  logic signed [OPA_W-1:0]   opa;
  logic signed [OPB_W-1:0]   opb;
  logic signed [SAMP_W:0]    asum;

  logic                      v1_q;
  step_t                     st1_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   pext, pshift, term, acc_d;

  logic                      v2_q;
  post_e                     post2_q;
  logic [1:0]                pidx2_q;
  logic signed [ACC_W-1:0]   acc_q;

  logic                      v3_q;
  logic [1:0]                cidx_q;
  logic signed [ACC_W-1:0]   inc_q;

  logic signed [ACC_W-1:0]   rnd_v, lin_v, acc16_v, vtot_v, vn_v, pnew_v;
  logic signed [VSUM_W-1:0]  vs_v;

  // operand selection for the issued step
  always_comb begin
    st   = step_at(cmd_i.step);
    asum = (SAMP_W + 1)'(aprev_q[st.a_idx]) + (SAMP_W + 1)'(anew_q[st.a_idx]);
    case (st.a_kind)
      AK_Q:    opa = OPA_W'(q_q[st.a_idx]);
      AK_G:    opa = grav_q[st.a_idx];
      AK_R:    opa = r_q[st.a_idx];
      AK_AS:   opa = OPA_W'(asum);
      AK_VH:   opa = OPA_W'($signed(vsum_q[st.a_idx][VSUM_W-1:VLO_W]));
      AK_VL:   opa = OPA_W'({1'b0, vsum_q[st.a_idx][VLO_W-1:0]});
      default: opa = '0;
    endcase
    case (st.b_kind)
      BK_Q:    opb = OPB_W'(q_q[st.b_idx]);
      BK_L:    opb = OPB_W'(lin_q[st.b_idx]);
      BK_CPG:  opb = OPB_W'({1'b0, cpg_q});
      BK_DT:   opb = OPB_W'({1'b0, dt_q});
      default: opb = '0;
    endcase
  end

  // accumulate
  always_comb begin
    pext = ACC_W'(prod_q);
    case (st1_q.shift)
      SH_1:    pshift = pext <<< 1;
      SH_24:   pshift = pext <<< 24;
      default: pshift = pext;
    endcase
    term  = st1_q.neg ? -pshift : pshift;
    acc_d = (st1_q.first ? '0 : acc_q) + term;
  end

  // post-processing of a finished accumulation
  always_comb begin
    rnd_v   = rnd28(acc_q);
    lin_v   = clamp(ACC_W'(raw_q[pidx2_q]) - rnd_v, S16_MIN, S16_MAX);
    acc16_v = clamp(rnd_v, S16_MIN, S16_MAX);
    vtot_v  = ACC_W'(vel_q[pidx2_q]) + acc_q;
    vn_v    = clamp(vtot_v, S48_MIN, S48_MAX);
    vs_v    = VSUM_W'(vel_q[pidx2_q]) + VSUM_W'($signed(vn_v[VEL_W-1:0]));
    pnew_v  = clamp(ACC_W'(pos_q[cidx_q]) + inc_q, S64_MIN, S64_MAX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpg_q <= CPG_RESET;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        aprev_q[i] <= '0;
        vel_q[i]   <= '0;
        pos_q[i]   <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        cpg_q <= cfg_data_i;
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q && (st1_q.post != PK_NONE);
      v3_q <= v2_q && (post2_q == PK_POS);
      // commit one axis of the integrator state
      if (v3_q) begin
        pos_q[cidx_q]   <= pnew_v[POS_W-1:0];
        vel_q[cidx_q]   <= vnew_q[cidx_q];
        aprev_q[cidx_q] <= anew_q[cidx_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      q_q[0]   <= in_item_i.quat_w;
      q_q[1]   <= in_item_i.quat_x;
      q_q[2]   <= in_item_i.quat_y;
      q_q[3]   <= in_item_i.quat_z;
      raw_q[0] <= in_item_i.accel_x;
      raw_q[1] <= in_item_i.accel_y;
      raw_q[2] <= in_item_i.accel_z;
      dt_q     <= in_item_i.dt_ticks;
    end
    if (cmd_i.issue) begin
      prod_q <= opa * opb;
      st1_q  <= st;
    end
    if (v1_q) begin
      acc_q   <= acc_d;
      post2_q <= st1_q.post;
      pidx2_q <= st1_q.post_idx;
    end
    if (v2_q) begin
      case (post2_q)
        PK_GRAV: grav_q[pidx2_q] <= acc_q[OPA_W-1:0];
        PK_LIN:  lin_q[pidx2_q]  <= lin_v[SAMP_W-1:0];
        PK_R:    r_q[pidx2_q]    <= acc_q[OPA_W-1:0];
        PK_ACC:  anew_q[pidx2_q] <= acc16_v[SAMP_W-1:0];
        PK_VEL: begin
          vnew_q[pidx2_q] <= vn_v[VEL_W-1:0];
          vsum_q[pidx2_q] <= vs_v;
        end
        PK_POS: begin
          inc_q  <= clamp(acc_q, S64_MIN, S64_MAX);
          cidx_q <= pidx2_q;
        end
        default: ;
      endcase
    end
    if (cmd_i.load_out) begin
      out_q.vel_x <= vel_q[0];
      out_q.vel_y <= vel_q[1];
      out_q.vel_z <= vel_q[2];
      out_q.pos_x <= pos_q[0];
      out_q.pos_y <= pos_q[1];
      out_q.pos_z <= pos_q[2];
    end
  end

  assign out_item_o = out_q;

endmodule
